// ===== src/sfr_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the sync frame receiver.
// No dependencies; every other file of the block imports this package.
package sfr_pkg;

  localparam int ByteW    = 8;
  localparam int PosOutW  = 6;
  localparam int CrcW     = 16;

  localparam logic [ByteW-1:0] SyncFirstReset  = 8'hFF;
  localparam logic [ByteW-1:0] SyncSecondReset = 8'hCC;
  localparam logic [CrcW-1:0]  CrcPoly         = 16'h1021;

  // Input item kinds
  localparam logic ModeByte    = 1'b0;
  localparam logic ModeRelease = 1'b1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SYNC_FIRST  = 1'b0,
    REG_SYNC_SECOND = 1'b1
  } cfg_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic take;   // store and check the offered byte
    logic load;   // move the next frame byte into the output register
  } sfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic at_last_pos;  // next byte completes the frame
    logic rd_at_last;   // burst read pointer sits on the final byte
    logic out_free;     // output register can take a byte this cycle
  } sfr_status_t;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [CrcW-1:0] crc16_byte(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/sfr_if.sv =====
// Handshake channel interfaces: received items, frame bytes, configuration writes.
// Depends on sfr_pkg for field widths and the register index type.
interface sfr_in_if;
  import sfr_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [ByteW-1:0] rx_byte;
  modport source (output valid, mode, rx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface sfr_out_if;
  import sfr_pkg::*;
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   frame_byte;
  logic [PosOutW-1:0] byte_pos;
  logic               last_byte;
  logic               crc_good;
  modport source (output valid, frame_byte, byte_pos, last_byte, crc_good, input ready);
  modport sink   (input valid, frame_byte, byte_pos, last_byte, crc_good, output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic             valid;
  logic             ready;
  cfg_reg_t         index;
  logic [ByteW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/sfr_ctrl.sv =====
// Controller FSM: hunt for a frame, burst it out, hold until release.
// Depends on sfr_pkg for the command and status structs.
module sfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_mode,
  output logic                 in_ready,
  input  sfr_pkg::sfr_status_t status,
  output sfr_pkg::sfr_cmd_t    cmd
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT  = 3'b001,
    ST_BURST = 3'b010,
    ST_HELD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_HUNT) || (state == ST_HELD);

  always_comb begin
    state_next = state;
    cmd.take   = 1'b0;
    cmd.load   = 1'b0;
    unique case (state)
      ST_HUNT: begin
        cmd.take = in_valid && (in_mode == ModeByte);
        if (cmd.take && status.at_last_pos) begin
          state_next = ST_BURST;
        end
      end
      ST_BURST: begin
        cmd.load = status.out_free;
        if (cmd.load && status.rd_at_last) begin
          state_next = ST_HELD;
        end
      end
      ST_HELD: begin
        // drop bytes, wait for release
        if (in_valid && (in_mode == ModeRelease)) begin
          state_next = ST_HUNT;
        end
      end
      default: state_next = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/sfr_dp.sv =====
// Datapath: sync registers, frame store, running CRC, burst read pointer, output register.
// Depends on sfr_pkg for widths, constants, structs and the CRC function.
module sfr_dp #(
  parameter int FRAME_LEN = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sfr_pkg::sfr_cmd_t           cmd,
  output sfr_pkg::sfr_status_t        status,
  input  logic [sfr_pkg::ByteW-1:0]   rx_byte,
  input  logic                        cfg_we,
  input  sfr_pkg::cfg_reg_t           cfg_index,
  input  logic [sfr_pkg::ByteW-1:0]   cfg_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [sfr_pkg::ByteW-1:0]   frame_byte,
  output logic [sfr_pkg::PosOutW-1:0] byte_pos,
  output logic                        last_byte,
  output logic                        crc_good
);
  import sfr_pkg::*;

  localparam int PosW = $clog2(FRAME_LEN);
  localparam logic [PosW-1:0] LastPos  = PosW'(FRAME_LEN - 1);
  localparam logic [PosW-1:0] CrcHiPos = PosW'(FRAME_LEN - 2);
  localparam logic [PosW-1:0] SyncPos0 = PosW'(0);
  localparam logic [PosW-1:0] SyncPos1 = PosW'(1);
  localparam logic [PosW-1:0] SyncPos2 = PosW'(2);

  logic [ByteW-1:0] sync_first;
  logic [ByteW-1:0] sync_second;
  logic [ByteW-1:0] store [FRAME_LEN];
  logic [PosW-1:0]  position;
  logic [PosW-1:0]  position_next;
  logic [CrcW-1:0]  running_crc;
  logic [CrcW-1:0]  running_crc_next;
  logic             good;
  logic             good_next;
  logic [PosW-1:0]  rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SyncFirstReset;
      sync_second <= SyncSecondReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  sync_first  <= cfg_data;
        REG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame position tracking and CRC over the payload bytes
  always_comb begin
    position_next    = position;
    running_crc_next = running_crc;
    good_next        = good;
    if (cmd.take) begin
      priority if (position == SyncPos0) begin
        if (rx_byte == sync_first) begin
          running_crc_next = '0;
          position_next    = SyncPos1;
        end
      end else if (position == SyncPos1) begin
        position_next = (rx_byte == sync_second) ? SyncPos2 : SyncPos0;
      end else if (position == LastPos) begin
        good_next        = ({store[CrcHiPos], rx_byte} == running_crc);
        position_next    = SyncPos0;
        running_crc_next = '0;
      end else begin
        if (position < CrcHiPos) begin
          running_crc_next = crc16_byte(running_crc, rx_byte);
        end
        position_next = position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      running_crc <= '0;
    end else begin
      position    <= position_next;
      running_crc <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    good <= good_next;
    if (cmd.take) begin
      store[position] <= rx_byte;
    end
  end

  // Burst read pointer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      rd_idx    <= (rd_idx == LastPos) ? '0 : rd_idx + 1'b1;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_byte <= store[rd_idx];
      byte_pos   <= PosOutW'(rd_idx);
      last_byte  <= (rd_idx == LastPos);
      crc_good   <= good;
    end
  end

  assign status.at_last_pos = (position == LastPos);
  assign status.rd_at_last  = (rd_idx == LastPos);
  assign status.out_free    = !out_valid || out_ready;

endmodule

// ===== src/sync_frame_receiver_crc_check.sv =====
// Sync frame receiver: hunts for a two-byte sync header, collects a fixed-length
// frame, checks its big-endian CRC-16 (poly 0x1021, init 0) and bursts the frame out.
// Once the final byte is accepted the controller enters the burst state and loads
// the stored bytes in order into the output register, waiting while it is full.
// Throughput: one received item per cycle while hunting.
// Reset (rst, synchronous): hunt at position 0, no frame held, sync bytes 0xFF / 0xCC.
module sync_frame_receiver_crc_check #(
  parameter int FRAME_LEN = 9
) (
  input  logic          clk,
  input  logic          rst,
  sfr_in_if.sink        rx,
  sfr_out_if.source     frame,
  sfr_cfg_if.sink       cfg
);
  import sfr_pkg::*;

  sfr_cmd_t    cmd;
  sfr_status_t status;

  // Configuration writes land at once; the port never stalls.
  assign cfg.ready = 1'b1;

  // Controller: owns the hunt / burst / hold sequencing and the input ready.
  // While a burst is going out, received items wait; while held, bytes are
  // accepted and dropped until a release item arrives.
  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_mode  (rx.mode),
    .in_ready (rx.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: frame store, CRC accumulation and the output register that
  // decouples the burst from the downstream ready.
  sfr_dp #(
    .FRAME_LEN (FRAME_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .rx_byte    (rx.rx_byte),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_ready  (frame.ready),
    .out_valid  (frame.valid),
    .frame_byte (frame.frame_byte),
    .byte_pos   (frame.byte_pos),
    .last_byte  (frame.last_byte),
    .crc_good   (frame.crc_good)
  );

endmodule

// ===== src/sfr_checker.sv =====
// Port-level assertions for the sync frame receiver, bound to the top level.
// Depends on sfr_pkg for field widths.
module sfr_checker #(
  parameter int FRAME_LEN = 9
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sfr_pkg::PosOutW-1:0] byte_pos,
  input logic                        last_byte,
  input logic                        crc_good
);
  import sfr_pkg::*;

  localparam logic [PosOutW-1:0] LastPos = PosOutW'(FRAME_LEN - 1);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("frame output valid after reset");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> byte_pos == LastPos)
    else $error("last byte not at final frame position");

  a_burst_advance: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_byte |=>
      out_valid && (byte_pos == $past(byte_pos) + 6'd1) && (crc_good == $past(crc_good)))
    else $error("burst did not advance to the next position with the same verdict");

  a_no_input_mid_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_byte |-> !in_ready)
    else $error("input accepted during a frame burst");

endmodule

bind sync_frame_receiver_crc_check sfr_checker #(
  .FRAME_LEN (FRAME_LEN)
) u_sfr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (rx.ready),
  .out_valid (frame.valid),
  .out_ready (frame.ready),
  .byte_pos  (frame.byte_pos),
  .last_byte (frame.last_byte),
  .crc_good  (frame.crc_good)
);
